### hdl/rer_pkg.sv
// rer_pkg: shared types and constants for the rotary embedding rotate unit
// no dependencies; imported by the front, queue, back and top-level modules
`timescale 1ns / 1ps

package rer_pkg;

    localparam int DATA_W               = 16;
    localparam int INDEX_W              = 8;
    localparam int HALF_W               = 8;
    localparam int OP_W                 = 2;
    localparam int MAX_HEAD_DIM_DEFAULT = 256;
    localparam int QUEUE_DEPTH_DEFAULT  = 4;

    localparam logic [HALF_W-1:0] HALF_DIM_RESET = 8'd64;

    // operation codes on the input channel
    localparam logic [OP_W-1:0] OP_ROTATE      = 2'd0;
    localparam logic [OP_W-1:0] OP_LOAD_SINE   = 2'd1;
    localparam logic [OP_W-1:0] OP_LOAD_COSINE = 2'd2;
    localparam logic [OP_W-1:0] OP_UNUSED      = 2'd3;

    // item class as decided by the front end
    typedef enum logic [1:0] {
        KIND_ROTATE      = 2'd0,
        KIND_LOAD_SINE   = 2'd1,
        KIND_LOAD_COSINE = 2'd2,
        KIND_ERROR       = 2'd3
    } rer_kind_t;

    localparam int KIND_W = $bits(rer_kind_t);

endpackage

### hdl/rotary_embedding_rotate_unit.sv
// rotary_embedding_rotate_unit: top level of the half-split rotary embedding rotator
// depends on rer_pkg, rer_front, rer_queue and rer_back
`timescale 1ns / 1ps

// Rotates one element pair per cycle in the half-split rotary position
// embedding layout. Load transfers (operation 1 or 2) write one sine or
// cosine table entry and produce no result; rotate transfers (operation 0)
// produce y_first = x0*cos[i] - x1*sin[i] and
// y_second = x0*sin[i+half_dim] + x1*cos[i+half_dim], rounded half up to
// Q4.12 and saturated, with saturated raised on any clip. A pair index not
// below half_dim, or whose partner reaches MAX_HEAD_DIM, gives index_error
// with zero data. Operation 3 and loads at or beyond MAX_HEAD_DIM are
// taken and dropped. While m_ready stays high the sustained rate is one
// transfer per cycle in and one result per cycle out. With an empty queue
// a rotate goes through the table read, product and round/saturate output
// registers before m_valid rises; items queued ahead of it go first.
// The rate is set by the tables, each a memory with one write
// port and two registered read ports, so both halves of a pair are read in
// the same cycle. A four-entry queue separates input acceptance from the
// arithmetic pipeline, so s_ready stays high for up to four more transfers
// while a result waits on m_ready; after that it drops until m_ready returns.
// Tables power up undefined: rotate only entries already loaded.
// A load followed directly by a rotate of the same entry sees the new value.
// half_dim resets to 64 and may be written only while the unit is idle.

module rotary_embedding_rotate_unit #(
    parameter int MAX_HEAD_DIM = rer_pkg::MAX_HEAD_DIM_DEFAULT,
    parameter int QUEUE_DEPTH  = rer_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    // configuration: half_dim
    input  logic                        cfg_we,
    input  logic [rer_pkg::HALF_W-1:0]  cfg_wdata,
    // input channel
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [rer_pkg::OP_W-1:0]    s_operation,
    input  logic [rer_pkg::INDEX_W-1:0] s_entry_index,
    input  logic signed [15:0]          s_x_first,
    input  logic signed [15:0]          s_x_second,
    input  logic signed [15:0]          s_table_value,
    // result channel
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic signed [15:0]          m_y_first,
    output logic signed [15:0]          m_y_second,
    output logic                        m_saturated,
    output logic                        m_index_error
);
    import rer_pkg::*;

    localparam int ADDR_W  = $clog2(MAX_HEAD_DIM);
    localparam int ENTRY_W = KIND_W + 2 * ADDR_W + 2 * DATA_W;

    logic [HALF_W-1:0] half_dim_reg;

    // front end outputs
    logic               f_keep;
    rer_kind_t          f_kind;
    logic [ADDR_W-1:0]  f_addr_first, f_addr_second;
    logic signed [15:0] f_x0, f_x1;

    // queue signals
    logic               q_full, q_not_empty, q_pop, q_push;
    logic [ENTRY_W-1:0] q_wr_data, q_rd_data;

    // queue head, unpacked
    rer_kind_t          h_kind;
    logic [ADDR_W-1:0]  h_addr_first, h_addr_second;
    logic signed [15:0] h_x0, h_x1;

    // half_dim register; the user must write it only while idle, the block does not enforce this
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            half_dim_reg <= HALF_DIM_RESET;
        end else if (cfg_we) begin
            half_dim_reg <= cfg_wdata;
        end
    end

    rer_front #(
        .MAX_HEAD_DIM (MAX_HEAD_DIM),
        .ADDR_W       (ADDR_W)
    ) u_front (
        .operation   (s_operation),
        .entry_index (s_entry_index),
        .x_first     (s_x_first),
        .x_second    (s_x_second),
        .table_value (s_table_value),
        .half_dim    (half_dim_reg),
        .keep        (f_keep),
        .kind        (f_kind),
        .addr_first  (f_addr_first),
        .addr_second (f_addr_second),
        .x0          (f_x0),
        .x1          (f_x1)
    );

    // accept whenever the queue has room; dropped items still complete the transfer
    assign s_ready   = !q_full;
    assign q_push    = s_valid && s_ready && f_keep;
    assign q_wr_data = {f_kind, f_addr_first, f_addr_second, f_x0, f_x1};

    rer_queue #(
        .ENTRY_W (ENTRY_W),
        .DEPTH   (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .wr_data   (q_wr_data),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .rd_data   (q_rd_data)
    );

    assign h_kind        = rer_kind_t'(q_rd_data[ENTRY_W-1 -: KIND_W]);
    assign h_addr_first  = q_rd_data[2*DATA_W+2*ADDR_W-1 -: ADDR_W];
    assign h_addr_second = q_rd_data[2*DATA_W+ADDR_W-1 -: ADDR_W];
    assign h_x0          = $signed(q_rd_data[2*DATA_W-1 -: DATA_W]);
    assign h_x1          = $signed(q_rd_data[DATA_W-1:0]);

    rer_back #(
        .MAX_HEAD_DIM (MAX_HEAD_DIM),
        .ADDR_W       (ADDR_W)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_not_empty   (q_not_empty),
        .q_kind        (h_kind),
        .q_addr_first  (h_addr_first),
        .q_addr_second (h_addr_second),
        .q_x0          (h_x0),
        .q_x1          (h_x1),
        .q_pop         (q_pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_y_first     (m_y_first),
        .m_y_second    (m_y_second),
        .m_saturated   (m_saturated),
        .m_index_error (m_index_error)
    );

endmodule

### hdl/rer_front.sv
// rer_front: classifies incoming items and works out table addresses
// depends on rer_pkg
`timescale 1ns / 1ps

module rer_front #(
    parameter int MAX_HEAD_DIM = rer_pkg::MAX_HEAD_DIM_DEFAULT,
    parameter int ADDR_W       = $clog2(MAX_HEAD_DIM)
) (
    input  logic [rer_pkg::OP_W-1:0]    operation,
    input  logic [rer_pkg::INDEX_W-1:0] entry_index,
    input  logic signed [15:0]          x_first,
    input  logic signed [15:0]          x_second,
    input  logic signed [15:0]          table_value,
    input  logic [rer_pkg::HALF_W-1:0]  half_dim,
    output logic                        keep,
    output rer_pkg::rer_kind_t          kind,
    output logic [ADDR_W-1:0]           addr_first,
    output logic [ADDR_W-1:0]           addr_second,
    output logic signed [15:0]          x0,
    output logic signed [15:0]          x1
);
    import rer_pkg::*;

    logic [INDEX_W:0] second_sum;
    logic             load_in_range;
    logic             pair_bad;

    assign second_sum    = {1'b0, entry_index} + {1'b0, half_dim};
    assign load_in_range = 32'(entry_index) < 32'(MAX_HEAD_DIM);
    assign pair_bad      = (entry_index >= half_dim) || (32'(second_sum) >= 32'(MAX_HEAD_DIM));

    assign addr_first  = ADDR_W'(entry_index);
    assign addr_second = ADDR_W'(second_sum);

    always_comb begin
        keep = 1'b0;
        kind = KIND_ERROR;
        x0   = x_first;
        x1   = x_second;
        unique case (operation)
            OP_ROTATE: begin
                keep = 1'b1;
                kind = pair_bad ? KIND_ERROR : KIND_ROTATE;
            end
            OP_LOAD_SINE: begin
                // table value rides in the first data slot
                keep = load_in_range;
                kind = KIND_LOAD_SINE;
                x0   = table_value;
            end
            OP_LOAD_COSINE: begin
                keep = load_in_range;
                kind = KIND_LOAD_COSINE;
                x0   = table_value;
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

endmodule

### hdl/rer_queue.sv
// rer_queue: small first-in first-out queue between front and back
// depends on rer_pkg for its default depth
`timescale 1ns / 1ps

module rer_queue #(
    parameter int ENTRY_W = 8,
    parameter int DEPTH   = rer_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  logic [ENTRY_W-1:0] wr_data,
    output logic               full,
    input  logic               pop,
    output logic               not_empty,
    output logic [ENTRY_W-1:0] rd_data
);
    import rer_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [ENTRY_W-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign rd_data   = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

### hdl/rer_back.sv
// rer_back: sine/cosine tables, multiply, round, saturate and output register
// depends on rer_pkg
`timescale 1ns / 1ps

module rer_back #(
    parameter int MAX_HEAD_DIM = rer_pkg::MAX_HEAD_DIM_DEFAULT,
    parameter int ADDR_W       = $clog2(MAX_HEAD_DIM)
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               q_not_empty,
    input  rer_pkg::rer_kind_t q_kind,
    input  logic [ADDR_W-1:0]  q_addr_first,
    input  logic [ADDR_W-1:0]  q_addr_second,
    input  logic signed [15:0] q_x0,
    input  logic signed [15:0] q_x1,
    output logic               q_pop,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [15:0] m_y_first,
    output logic signed [15:0] m_y_second,
    output logic               m_saturated,
    output logic               m_index_error
);
    import rer_pkg::*;

    localparam int SUM_W = 34;
    localparam logic signed [SUM_W-1:0] ROUND_BIAS = 34'sd8192;

    logic signed [15:0] sine_mem   [MAX_HEAD_DIM];
    logic signed [15:0] cosine_mem [MAX_HEAD_DIM];

    logic advance;

    // stage 1: table read data and operands
    logic               valid1_reg, err1_reg;
    logic signed [15:0] x0_1_reg, x1_1_reg;
    logic signed [15:0] cos_i_reg, sin_i_reg, sin_j_reg, cos_j_reg;

    // stage 2: products
    logic               valid2_reg, err2_reg;
    logic signed [31:0] prod_a_reg, prod_b_reg, prod_c_reg, prod_d_reg;

    // stage 3: output register
    logic               out_valid_reg;
    logic signed [15:0] y0_reg, y1_reg;
    logic               sat_reg, err_reg;

    logic signed [SUM_W-1:0] sum0, sum1;
    logic [19:0]             round0, round1;
    logic                    clip0, clip1;
    logic signed [15:0]      y0_next, y1_next;

    assign advance = !out_valid_reg || m_ready;
    assign q_pop   = advance && q_not_empty;

    // table writes and two-port reads
    always_ff @(posedge aclk) begin
        if (q_pop && q_kind == KIND_LOAD_SINE) begin
            sine_mem[q_addr_first] <= q_x0;
        end
        if (q_pop && q_kind == KIND_LOAD_COSINE) begin
            cosine_mem[q_addr_first] <= q_x0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            cos_i_reg <= cosine_mem[q_addr_first];
            sin_i_reg <= sine_mem[q_addr_first];
            sin_j_reg <= sine_mem[q_addr_second];
            cos_j_reg <= cosine_mem[q_addr_second];
        end
    end

    // payload stages
    always_ff @(posedge aclk) begin
        if (advance) begin
            x0_1_reg   <= q_x0;
            x1_1_reg   <= q_x1;
            err1_reg   <= (q_kind == KIND_ERROR);
            prod_a_reg <= x0_1_reg * cos_i_reg;
            prod_b_reg <= x1_1_reg * sin_i_reg;
            prod_c_reg <= x0_1_reg * sin_j_reg;
            prod_d_reg <= x1_1_reg * cos_j_reg;
            err2_reg   <= err1_reg;
            y0_reg     <= y0_next;
            y1_reg     <= y1_next;
            sat_reg    <= (clip0 || clip1) && !err2_reg;
            err_reg    <= err2_reg;
        end
    end

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid1_reg    <= 1'b0;
            valid2_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            valid1_reg    <= q_pop && (q_kind == KIND_ROTATE || q_kind == KIND_ERROR);
            valid2_reg    <= valid1_reg;
            out_valid_reg <= valid2_reg;
        end
    end

    // round half up to Q4.12, then saturate
    assign sum0   = SUM_W'(prod_a_reg) - SUM_W'(prod_b_reg) + ROUND_BIAS;
    assign sum1   = SUM_W'(prod_c_reg) + SUM_W'(prod_d_reg) + ROUND_BIAS;
    assign round0 = sum0[SUM_W-1:14];
    assign round1 = sum1[SUM_W-1:14];
    assign clip0  = !(round0[19:15] == 5'b00000 || round0[19:15] == 5'b11111);
    assign clip1  = !(round1[19:15] == 5'b00000 || round1[19:15] == 5'b11111);

    always_comb begin
        if (err2_reg) begin
            y0_next = '0;
            y1_next = '0;
        end else begin
            y0_next = clip0 ? (round0[19] ? 16'sh8000 : 16'sh7fff) : $signed(round0[15:0]);
            y1_next = clip1 ? (round1[19] ? 16'sh8000 : 16'sh7fff) : $signed(round1[15:0]);
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_y_first     = y0_reg;
    assign m_y_second    = y1_reg;
    assign m_saturated   = sat_reg;
    assign m_index_error = err_reg;

`ifndef SYNTHESIS
    a_error_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_index_error |-> m_y_first == 0 && m_y_second == 0 && !m_saturated)
        else $error("index error result carries nonzero payload");

    a_pop_only_on_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> q_not_empty && (!out_valid_reg || m_ready))
        else $error("queue popped while pipeline stalled");

    a_stall_holds_stage2: assert property (@(posedge aclk) disable iff (!aresetn)
        valid2_reg && !advance |=> valid2_reg)
        else $error("stage 2 item lost during stall");

    a_output_from_stage2: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(valid2_reg))
        else $error("result appeared without a stage 2 item");
`endif

endmodule
